>>> hdl/sfrc_pkg.sv
package sfrc_pkg;

   localparam int FIELD_BITS = 16;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch range, first n, clear count
      logic count_free;  // current n is square-free
      logic mod_start;   // begin n mod sq
      logic mod_step;    // one restoring step
      logic next_trial;  // move to the next square
      logic next_n;      // advance n, restart squares
      logic load_out;    // capture result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic lo_gt_hi;
      logic n_zero;
      logic sq_gt_n;
      logic mod_last;
      logic rem_zero;
      logic n_is_hi;
   } status_type;

endpackage

>>> hdl/sfrc_if.sv
interface sfrc_req_if;
   logic                            valid;
   logic                            ready;
   logic [sfrc_pkg::FIELD_BITS-1:0] lower;
   logic [sfrc_pkg::FIELD_BITS-1:0] upper;

   modport source (output valid, output lower, output upper, input ready);
   modport sink   (input valid, input lower, input upper, output ready);
endinterface

interface sfrc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sfrc_pkg::FIELD_BITS-1:0] free_count;
   logic                            empty_range;

   modport source (output valid, output free_count, output empty_range, input ready);
   modport sink   (input valid, input free_count, input empty_range, output ready);
endinterface

>>> hdl/square_free_range_counter.sv
// Each n in [lower, upper] is tried against the squares from 4 upward until one divides n
// or exceeds it; n = 0 is never counted, and an empty range goes straight to the result.
// Each trial runs a bit-serial restoring modulo, one dividend bit per cycle.
// One request is worked on at a time; the next is taken while a result waits.
// Synchronous active-high reset clears the controller and the output valid.
module square_free_range_counter #(
   parameter int VALUE_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   sfrc_req_if.sink  req_ch,
   sfrc_rsp_if.source rsp_ch
);

   sfrc_pkg::cmd_type    cmd;
   sfrc_pkg::status_type status;

   sfrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfrc_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock       (clock),
      .lower       (req_ch.lower),
      .upper       (req_ch.upper),
      .cmd         (cmd),
      .status      (status),
      .free_count  (rsp_ch.free_count),
      .empty_range (rsp_ch.empty_range)
   );

endmodule

>>> hdl/sfrc_dp.sv
module sfrc_dp #(
   parameter int VALUE_BITS = 16
) (
   input  logic                            clock,
   input  logic [sfrc_pkg::FIELD_BITS-1:0] lower,
   input  logic [sfrc_pkg::FIELD_BITS-1:0] upper,
   input  sfrc_pkg::cmd_type               cmd,
   output sfrc_pkg::status_type            status,
   output logic [sfrc_pkg::FIELD_BITS-1:0] free_count,
   output logic                            empty_range
);

   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam logic [32:0] COUNT_MAX = 33'd65535;

   logic [31:0] lower_ext, upper_ext;
   logic [VALUE_BITS-1:0] lo, hi;

   logic [VALUE_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in, n_ff, n_in;
   logic [VALUE_BITS:0]   sq_ff, sq_in, d_ff, d_in;
   logic [VALUE_BITS:0]   free_ff, free_in;
   logic [VALUE_BITS-1:0] r_ff, r_in, sh_ff, sh_in;
   logic [CNT_BITS-1:0]   bit_ff, bit_in;
   logic [sfrc_pkg::FIELD_BITS-1:0] fc_ff, fc_in;
   logic                  er_ff, er_in;

   logic [VALUE_BITS:0] trial, diff;
   logic [32:0]         free_wide;

   assign lower_ext = 32'(lower);
   assign upper_ext = 32'(upper);
   assign lo = lower_ext[VALUE_BITS-1:0];
   assign hi = upper_ext[VALUE_BITS-1:0];

   assign trial     = {r_ff, sh_ff[VALUE_BITS-1]};
   assign diff      = trial - sq_ff;
   assign free_wide = 33'(free_ff);

   always_comb begin
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      n_in    = n_ff;
      sq_in   = sq_ff;
      d_in    = d_ff;
      free_in = free_ff;
      r_in    = r_ff;
      sh_in   = sh_ff;
      bit_in  = bit_ff;
      fc_in   = fc_ff;
      er_in   = er_ff;
      if (cmd.load) begin
         lo_in   = lo;
         hi_in   = hi;
         n_in    = lo;
         sq_in   = (VALUE_BITS+1)'(4);
         d_in    = (VALUE_BITS+1)'(5);
         free_in = '0;
      end
      if (cmd.count_free) free_in = free_ff + 1'b1;
      if (cmd.mod_start) begin
         r_in   = '0;
         sh_in  = n_ff;
         bit_in = CNT_BITS'(VALUE_BITS-1);
      end
      if (cmd.mod_step) begin
         // restoring step: bring in next dividend bit, subtract if it fits
         r_in   = (trial >= sq_ff) ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
         sh_in  = {sh_ff[VALUE_BITS-2:0], 1'b0};
         bit_in = bit_ff - 1'b1;
      end
      if (cmd.next_trial) begin
         // (i+1)^2 = i^2 + 2i + 1
         sq_in = sq_ff + d_ff;
         d_in  = d_ff + (VALUE_BITS+1)'(2);
      end
      if (cmd.next_n) begin
         n_in  = n_ff + 1'b1;
         sq_in = (VALUE_BITS+1)'(4);
         d_in  = (VALUE_BITS+1)'(5);
      end
      if (cmd.load_out) begin
         fc_in = (free_wide > COUNT_MAX) ? 16'hFFFF : free_wide[15:0];
         er_in = lo_ff > hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      n_ff    <= n_in;
      sq_ff   <= sq_in;
      d_ff    <= d_in;
      free_ff <= free_in;
      r_ff    <= r_in;
      sh_ff   <= sh_in;
      bit_ff  <= bit_in;
      fc_ff   <= fc_in;
      er_ff   <= er_in;
   end

   always_comb begin
      status.lo_gt_hi = lo_ff > hi_ff;
      status.n_zero   = n_ff == '0;
      status.sq_gt_n  = sq_ff > {1'b0, n_ff};
      status.mod_last = bit_ff == '0;
      status.rem_zero = r_ff == '0;
      status.n_is_hi  = n_ff == hi_ff;
   end

   assign free_count  = fc_ff;
   assign empty_range = er_ff;

endmodule

>>> hdl/sfrc_ctrl.sv
module sfrc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sfrc_pkg::status_type status,
   output sfrc_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      IDLE   = 7'b0000001,
      START  = 7'b0000010,
      NUM    = 7'b0000100,
      MODS   = 7'b0001000,
      EVAL   = 7'b0010000,
      NEXTN  = 7'b0100000,
      FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign req_ready = state_ff == IDLE;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      valid_in = valid_ff && !rsp_ready;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = START;
            end
         end
         START: begin
            state_in = status.lo_gt_hi ? FINISH : NUM;
         end
         NUM: begin
            if (status.n_zero) begin
               state_in = NEXTN;
            end else if (status.sq_gt_n) begin
               cmd.count_free = 1'b1;
               state_in       = NEXTN;
            end else begin
               cmd.mod_start = 1'b1;
               state_in      = MODS;
            end
         end
         MODS: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) state_in = EVAL;
         end
         EVAL: begin
            if (status.rem_zero) begin
               state_in = NEXTN;
            end else begin
               cmd.next_trial = 1'b1;
               state_in       = NUM;
            end
         end
         NEXTN: begin
            if (status.n_is_hi) begin
               state_in = FINISH;
            end else begin
               cmd.next_n = 1'b1;
               state_in   = NUM;
            end
         end
         FINISH: begin
            // hold until the output register is free
            if (!valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> tb/tb.sv
module tb;

   localparam int VALUE_BITS = 16;
   localparam int COUNT_MAX  = 65535;
   localparam int MAX_GAP    = 12;
   localparam int MAX_REPORT = 10;

   typedef struct packed {
      logic [sfrc_pkg::FIELD_BITS-1:0] lower;
      logic [sfrc_pkg::FIELD_BITS-1:0] upper;
   } range_type;

   typedef struct packed {
      logic [sfrc_pkg::FIELD_BITS-1:0] free_count;
      logic                            empty_range;
   } tally_type;

   logic clock;
   logic reset;

   sfrc_req_if req_if();
   sfrc_rsp_if rsp_if();

   square_free_range_counter #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   range_type range_queue[$];
   tally_type tally_queue[$];

   bit        req_taken;
   bit        rsp_taken;
   int        gap_left;
   int        stall_left;
   bit        calm_req;
   bit        calm_rsp;
   range_type next_range;

   int     n_sent;
   int     n_checked;
   int     n_empty;
   int     n_zero_incl;
   int     n_errors;

   function automatic bit has_square_divisor(int unsigned n);
      int unsigned i;
      if (n == 0)
         return 1'b1;
      for (i = 2; i * i <= n; i++)
         if (n % (i * i) == 0)
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic tally_type count_square_free(range_type r);
      tally_type   t;
      int unsigned lo;
      int unsigned hi;
      int unsigned n;
      int unsigned squared;
      int unsigned freec;
      lo = r.lower & ((1 << VALUE_BITS) - 1);
      hi = r.upper & ((1 << VALUE_BITS) - 1);
      t = '0;
      if (lo > hi) begin
         t.empty_range = 1'b1;
         return t;
      end
      squared = 0;
      for (n = lo; n <= hi; n++)
         if (has_square_divisor(n))
            squared++;
      freec = hi - lo + 1 - squared;
      if (freec > COUNT_MAX)
         freec = COUNT_MAX;
      t.free_count = freec[sfrc_pkg::FIELD_BITS-1:0];
      return t;
   endfunction

   function automatic int draw_wait(bit calm);
      if (calm)
         return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   task automatic add_range(int lo, int hi);
      range_type r;
      r.lower = lo[sfrc_pkg::FIELD_BITS-1:0];
      r.upper = hi[sfrc_pkg::FIELD_BITS-1:0];
      range_queue.push_back(r);
   endtask

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // request side, driven on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (req_taken) begin
            if ($urandom_range(0, 7) == 0)
               calm_req = !calm_req;
            gap_left = draw_wait(calm_req);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (range_queue.size() > 0) begin
            next_range = range_queue.pop_front();
            req_if.lower <= next_range.lower;
            req_if.upper <= next_range.upper;
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 7) == 0)
               calm_rsp = !calm_rsp;
            stall_left = draw_wait(calm_rsp);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // sample both handshakes on the rising edge
   always @(posedge clock) begin
      tally_type want;
      range_type got_range;
      req_taken <= !reset && req_if.valid && req_if.ready;
      rsp_taken <= !reset && rsp_if.valid && rsp_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         got_range.lower = req_if.lower;
         got_range.upper = req_if.upper;
         tally_queue.push_back(count_square_free(got_range));
         n_sent++;
         if (got_range.lower > got_range.upper)
            n_empty++;
         else if (got_range.lower == 0)
            n_zero_incl++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (tally_queue.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORT)
               $display("unexpected result: free_count=%0d empty_range=%0b",
                        rsp_if.free_count, rsp_if.empty_range);
         end else begin
            want = tally_queue.pop_front();
            n_checked++;
            if (rsp_if.free_count !== want.free_count ||
                rsp_if.empty_range !== want.empty_range) begin
               n_errors++;
               if (n_errors <= MAX_REPORT)
                  $display({"mismatch on result %0d: free_count exp %0d got %0d,",
                            " empty_range exp %0b got %0b"},
                           n_checked, want.free_count, rsp_if.free_count,
                           want.empty_range, rsp_if.empty_range);
            end
         end
      end
   end

   initial begin
      int k;
      int lo;
      int hi;
      int kind;
      clock        = 1'b0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.lower = '0;
      req_if.upper = '0;
      rsp_if.ready = 1'b0;
      req_taken    = 1'b0;
      rsp_taken    = 1'b0;
      gap_left     = 0;
      stall_left   = 0;
      calm_req     = 1'b0;
      calm_rsp     = 1'b0;
      n_sent       = 0;
      n_checked    = 0;
      n_empty      = 0;
      n_zero_incl  = 0;
      n_errors     = 0;

      // directed ranges: edges of the fields, zero and one, empty ranges,
      // perfect squares near the top
      add_range(1, 1);
      add_range(0, 0);
      add_range(0, 5);
      add_range(1, 10);
      add_range(4, 4);
      add_range(48, 50);
      add_range(1, 100);
      add_range(1, 255);
      add_range(65535, 65535);
      add_range(65535, 1);
      add_range(2, 1);
      add_range(100, 99);
      add_range(65535, 65534);
      add_range(65534, 65535);
      add_range(65020, 65030);
      add_range(65500, 65535);
      add_range(32768, 32770);
      add_range(16'h5555, 16'h5557);
      add_range(16'hAAAA, 16'hAAAC);

      // random ranges; wide ones stay low in value to keep the run short
      for (k = 0; k < 81; k++) begin
         kind = $urandom_range(0, 19);
         if (kind < 3) begin
            lo = $urandom_range(2, 65535);
            hi = $urandom_range(1, lo - 1);
         end else if (kind < 9) begin
            lo = $urandom_range(1, 65535);
            hi = lo + $urandom_range(0, 3);
            if (hi > 65535)
               hi = 65535;
         end else begin
            lo = $urandom_range(1, 300);
            hi = lo + $urandom_range(0, 40);
         end
         add_range(lo, hi);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (range_queue.size() > 0 || req_if.valid || tally_queue.size() > 0);
      repeat (50) @(negedge clock);

      $display("%0d ranges sent, %0d results checked (%0d empty, %0d including zero)",
               n_sent, n_checked, n_empty, n_zero_incl);
      $display("%0d mismatches", n_errors);
      if (n_errors == 0 && tally_queue.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #20000000;
      $display("timed out with %0d results outstanding", tally_queue.size());
      $display("FAILURE");
      $finish;
   end

endmodule
